FILE: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and defaults for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int BPA_NUM_PAGES  = 4096;
   localparam int BPA_TOP_ORDER  = 6;
   localparam int BPA_PAGE_BYTES = 4096;
   localparam int BPA_PAGE_W     = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_FREE   = 2'd2;
   localparam logic [1:0] ST_BAD_FREE  = 2'd3;

   localparam int CMD_W = 5;
   localparam logic [CMD_W-1:0] CMD_NONE    = 5'd0;
   localparam logic [CMD_W-1:0] CMD_INIT    = 5'd1;
   localparam logic [CMD_W-1:0] CMD_LATCH   = 5'd2;
   localparam logic [CMD_W-1:0] CMD_A_LVL   = 5'd3;
   localparam logic [CMD_W-1:0] CMD_A_HEAD  = 5'd4;
   localparam logic [CMD_W-1:0] CMD_UL_R    = 5'd5;
   localparam logic [CMD_W-1:0] CMD_UL_W1   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_UL_W2   = 5'd7;
   localparam logic [CMD_W-1:0] CMD_A_SPLIT = 5'd8;
   localparam logic [CMD_W-1:0] CMD_A_GRANT = 5'd9;
   localparam logic [CMD_W-1:0] CMD_F_READ  = 5'd10;
   localparam logic [CMD_W-1:0] CMD_F_CHK   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_F_BUD   = 5'd12;
   localparam logic [CMD_W-1:0] CMD_F_MERGE = 5'd13;
   localparam logic [CMD_W-1:0] CMD_F_FIN   = 5'd14;
   localparam logic [CMD_W-1:0] CMD_PUSH1   = 5'd15;
   localparam logic [CMD_W-1:0] CMD_PUSH2   = 5'd16;
   localparam logic [CMD_W-1:0] CMD_ERR     = 5'd17;
   localparam logic [CMD_W-1:0] CMD_RSP     = 5'd18;

   typedef struct packed {
      logic        opcode;
      logic [31:0] request_size;
      logic [11:0] page_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted_page;
      logic [2:0]  granted_order;
   } rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0] code;
      logic [1:0]       err;
   } bpa_cmd_type;

   typedef struct packed {
      logic init_last;
      logic is_alloc;
      logic fits;
      logic found;
      logic idx_ok;
      logic free_ok;
      logic bud_go;
      logic bud_ok;
      logic split_more;
      logic up_ok;
      logic rsp_busy;
   } bpa_stat_type;

endpackage

FILE: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: walks init sweep, split and merge steps, issues datapath commands.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bpa_pkg::bpa_stat_type stat,
   output bpa_pkg::bpa_cmd_type  cmd
);
   import bpa_pkg::*;

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_A_HEAD  = 4'd3;
   localparam logic [3:0] S_UL_R    = 4'd4;
   localparam logic [3:0] S_UL_W1   = 4'd5;
   localparam logic [3:0] S_UL_W2   = 4'd6;
   localparam logic [3:0] S_A_SPLIT = 4'd7;
   localparam logic [3:0] S_F_CHK   = 4'd8;
   localparam logic [3:0] S_F_BUD   = 4'd9;
   localparam logic [3:0] S_F_BCHK  = 4'd10;
   localparam logic [3:0] S_F_MERGE = 4'd11;
   localparam logic [3:0] S_F_FIN   = 4'd12;
   localparam logic [3:0] S_PUSH1   = 4'd13;
   localparam logic [3:0] S_PUSH2   = 4'd14;
   localparam logic [3:0] S_DONE    = 4'd15;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      cmd.err  = ST_OK;
      case (state_ff)
         S_INIT: begin
            cmd.code = CMD_INIT;
            if (stat.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_alloc) begin
               if (!stat.fits) begin
                  cmd.code = CMD_ERR;
                  cmd.err  = ST_TOO_LARGE;
                  state_in = S_DONE;
               end else if (!stat.found) begin
                  cmd.code = CMD_ERR;
                  cmd.err  = ST_NO_FREE;
                  state_in = S_DONE;
               end else begin
                  cmd.code = CMD_A_LVL;
                  state_in = S_A_HEAD;
               end
            end else if (!stat.idx_ok) begin
               cmd.code = CMD_ERR;
               cmd.err  = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               cmd.code = CMD_F_READ;
               state_in = S_F_CHK;
            end
         end
         S_A_HEAD: begin
            cmd.code = CMD_A_HEAD;
            state_in = S_UL_R;
         end
         S_UL_R: begin
            cmd.code = CMD_UL_R;
            state_in = S_UL_W1;
         end
         S_UL_W1: begin
            cmd.code = CMD_UL_W1;
            state_in = S_UL_W2;
         end
         S_UL_W2: begin
            cmd.code = CMD_UL_W2;
            state_in = stat.is_alloc ? S_A_SPLIT : S_F_MERGE;
         end
         S_A_SPLIT: begin
            if (stat.split_more) begin
               cmd.code = CMD_A_SPLIT;
               if (stat.up_ok) state_in = S_PUSH1;
            end else begin
               cmd.code = CMD_A_GRANT;
               state_in = S_DONE;
            end
         end
         S_F_CHK: begin
            if (!stat.free_ok) begin
               cmd.code = CMD_ERR;
               cmd.err  = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               cmd.code = CMD_F_CHK;
               state_in = S_F_BUD;
            end
         end
         S_F_BUD: begin
            if (stat.bud_go) begin
               cmd.code = CMD_F_BUD;
               state_in = S_F_BCHK;
            end else begin
               state_in = S_F_FIN;
            end
         end
         S_F_BCHK: begin
            state_in = stat.bud_ok ? S_UL_R : S_F_FIN;
         end
         S_F_MERGE: begin
            cmd.code = CMD_F_MERGE;
            state_in = S_F_BUD;
         end
         S_F_FIN: begin
            cmd.code = CMD_F_FIN;
            state_in = S_PUSH1;
         end
         S_PUSH1: begin
            cmd.code = CMD_PUSH1;
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            cmd.code = CMD_PUSH2;
            state_in = stat.is_alloc ? S_A_SPLIT : S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.code = CMD_RSP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end
endmodule

FILE: rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Block tables in RAM, free list heads, working registers and result stage.
// ----------------------------------------------------------------------------
module bpa_datapath #(
   parameter int NUM_PAGES = bpa_pkg::BPA_NUM_PAGES,
   parameter int TOP_ORDER = bpa_pkg::BPA_TOP_ORDER
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bpa_pkg::req_type      req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bpa_pkg::rsp_type      rsp_payload,
   input  bpa_pkg::bpa_cmd_type  cmd,
   output bpa_pkg::bpa_stat_type stat
);
   import bpa_pkg::*;

   localparam int PG_W      = $clog2(NUM_PAGES);
   localparam int LINK_W    = $clog2(NUM_PAGES + 1);
   localparam int ORD_W     = $clog2(TOP_ORDER + 1);
   localparam int META_W    = ORD_W + 2;
   localparam int NUM_LISTS = TOP_ORDER + 1;
   localparam int SPAN      = 1 << TOP_ORDER;
   localparam int TOP_HEADS = NUM_PAGES / SPAN;
   localparam int HIGH_HEAD = (TOP_HEADS > 0) ? (TOP_HEADS - 1) * SPAN : NUM_PAGES;
   localparam logic [LINK_W-1:0] NIL_L = LINK_W'(NUM_PAGES);

   // working registers
   logic              is_alloc_ff, is_alloc_in;
   logic [31:0]       size_ff, size_in;
   logic [11:0]       idx_ff, idx_in;
   logic [ORD_W-1:0]  need_ff, need_in;
   logic [ORD_W-1:0]  lvl_ff, lvl_in;
   logic [PG_W-1:0]   p_ff, p_in;
   logic [PG_W-1:0]   t_ff, t_in;
   logic [LINK_W-1:0] nx_ff, nx_in;
   logic [LINK_W-1:0] pv_ff, pv_in;
   logic [PG_W-1:0]   init_cnt_ff, init_cnt_in;
   logic [LINK_W-1:0] list_head_ff [NUM_LISTS];
   logic [LINK_W-1:0] list_head_in [NUM_LISTS];
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic              meta_we, next_we, prev_we;
   logic [PG_W-1:0]   meta_wa, next_wa, prev_wa, meta_ra, link_ra;
   logic [META_W-1:0] meta_wd, meta_rd;
   logic [LINK_W-1:0] next_wd, next_rd, prev_wd, prev_rd;

   bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta (
      .clock(clock), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
      .raddr(meta_ra), .rdata(meta_rd));
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(link_ra), .rdata(next_rd));
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(link_ra), .rdata(prev_rd));

   // decode of the latched size and the list heads
   logic [ORD_W-1:0] need_c, kf_c;
   logic             fits_c, found_c;
   always_comb begin
      need_c  = '0;
      fits_c  = 1'b0;
      kf_c    = '0;
      found_c = 1'b0;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if ({32'd0, size_ff} <= (64'(BPA_PAGE_BYTES) << k)) begin
            need_c = ORD_W'(k);
            fits_c = 1'b1;
         end
      end
      for (int k = 0; k < NUM_LISTS; k++) begin
         if (!found_c && (32'(k) >= 32'(need_c)) && (list_head_ff[k] != NIL_L)) begin
            found_c = 1'b1;
            kf_c    = ORD_W'(k);
         end
      end
   end

   logic [ORD_W-1:0] half;
   logic [31:0]      up32, bud32, init32;
   logic             m_head, m_free, init_head;
   logic [ORD_W-1:0] m_ord;
   logic [PG_W-1:0]  lo_pg, hi_pg;

   assign half   = lvl_ff - ORD_W'(1);
   assign up32   = 32'(p_ff) + (32'd1 << half);
   assign bud32  = 32'(p_ff) ^ (32'd1 << lvl_ff);
   assign m_head = meta_rd[ORD_W+1];
   assign m_free = meta_rd[ORD_W];
   assign m_ord  = meta_rd[ORD_W-1:0];
   assign lo_pg  = (p_ff < t_ff) ? p_ff : t_ff;
   assign hi_pg  = (p_ff < t_ff) ? t_ff : p_ff;
   assign init32 = 32'(init_cnt_ff);
   assign init_head = ((init32 % SPAN) == 0) && (init32 + SPAN <= NUM_PAGES);

   always_comb begin
      stat.init_last  = (init32 == NUM_PAGES - 1);
      stat.is_alloc   = is_alloc_ff;
      stat.fits       = fits_c;
      stat.found      = found_c;
      stat.idx_ok     = (32'(idx_ff) < NUM_PAGES);
      stat.free_ok    = m_head && !m_free;
      stat.bud_go     = (32'(lvl_ff) < TOP_ORDER) && (bud32 < NUM_PAGES);
      stat.bud_ok     = m_head && m_free && (m_ord == lvl_ff);
      stat.split_more = (lvl_ff > need_ff);
      stat.up_ok      = (up32 < NUM_PAGES);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      is_alloc_in  = is_alloc_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      need_in      = need_ff;
      lvl_in       = lvl_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      init_cnt_in  = init_cnt_ff;
      list_head_in = list_head_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      meta_we = 1'b0; meta_wa = p_ff; meta_wd = '0;
      next_we = 1'b0; next_wa = t_ff; next_wd = NIL_L;
      prev_we = 1'b0; prev_wa = t_ff; prev_wd = NIL_L;
      meta_ra = p_ff;
      link_ra = t_ff;
      case (cmd.code)
         CMD_INIT: begin
            init_cnt_in = init_cnt_ff + PG_W'(1);
            meta_we = 1'b1; meta_wa = init_cnt_ff;
            meta_wd = init_head ? {2'b11, ORD_W'(TOP_ORDER)} : '0;
            next_we = 1'b1; next_wa = init_cnt_ff;
            next_wd = (init_head && init32 != 0) ? LINK_W'(init32 - SPAN) : NIL_L;
            prev_we = 1'b1; prev_wa = init_cnt_ff;
            prev_wd = (init_head && (init32 + 2 * SPAN <= NUM_PAGES)) ?
                      LINK_W'(init32 + SPAN) : NIL_L;
         end
         CMD_LATCH: begin
            is_alloc_in = (req_payload.opcode == OP_ALLOC);
            size_in     = req_payload.request_size;
            idx_in      = req_payload.page_index;
         end
         CMD_A_LVL: begin
            need_in = need_c;
            lvl_in  = kf_c;
         end
         CMD_A_HEAD: begin
            p_in = PG_W'(list_head_ff[lvl_ff]);
            t_in = PG_W'(list_head_ff[lvl_ff]);
         end
         CMD_UL_R: link_ra = t_ff;
         CMD_UL_W1: begin
            nx_in = next_rd;
            pv_in = prev_rd;
            if (prev_rd < NIL_L) begin
               next_we = 1'b1; next_wa = PG_W'(prev_rd); next_wd = next_rd;
            end else begin
               list_head_in[lvl_ff] = next_rd;
            end
         end
         CMD_UL_W2: begin
            if (nx_ff < NIL_L) begin
               prev_we = 1'b1; prev_wa = PG_W'(nx_ff); prev_wd = pv_ff;
            end
         end
         CMD_A_SPLIT: begin
            lvl_in = half;
            t_in   = PG_W'(up32);
            if (up32 < NUM_PAGES) begin
               meta_we = 1'b1; meta_wa = PG_W'(up32); meta_wd = {2'b11, half};
            end
         end
         CMD_A_GRANT: begin
            meta_we = 1'b1; meta_wa = p_ff; meta_wd = {2'b10, need_ff};
            res_in.status        = ST_OK;
            res_in.granted_page  = 12'(32'(p_ff));
            res_in.granted_order = 3'(32'(need_ff));
         end
         CMD_F_READ: begin
            meta_ra = PG_W'(32'(idx_ff));
            p_in    = PG_W'(32'(idx_ff));
         end
         CMD_F_CHK: lvl_in = m_ord;
         CMD_F_BUD: begin
            meta_ra = PG_W'(bud32);
            t_in    = PG_W'(bud32);
         end
         CMD_F_MERGE: begin
            meta_we = 1'b1; meta_wa = hi_pg; meta_wd = '0;
            p_in    = lo_pg;
            lvl_in  = lvl_ff + ORD_W'(1);
         end
         CMD_F_FIN: begin
            meta_we = 1'b1; meta_wa = p_ff; meta_wd = {2'b11, lvl_ff};
            t_in    = p_ff;
         end
         CMD_PUSH1: begin
            // new head goes in front of the current one at this order
            nx_in   = list_head_ff[lvl_ff];
            next_we = 1'b1; next_wa = t_ff; next_wd = list_head_ff[lvl_ff];
            prev_we = 1'b1; prev_wa = t_ff; prev_wd = NIL_L;
            list_head_in[lvl_ff] = LINK_W'(t_ff);
         end
         CMD_PUSH2: begin
            if (nx_ff < NIL_L) begin
               prev_we = 1'b1; prev_wa = PG_W'(nx_ff); prev_wd = LINK_W'(t_ff);
            end
            res_in.status        = ST_OK;
            res_in.granted_page  = 12'(32'(p_ff));
            res_in.granted_order = 3'(32'(lvl_ff));
         end
         CMD_ERR: begin
            res_in.status        = cmd.err;
            res_in.granted_page  = '0;
            res_in.granted_order = '0;
         end
         CMD_RSP: begin
            rsp_in       = res_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      idx_ff   <= idx_in;
      need_ff  <= need_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      nx_ff    <= nx_in;
      pv_ff    <= pv_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         is_alloc_ff  <= 1'b0;
         lvl_ff       <= '0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_LISTS; k++) begin
            list_head_ff[k] <= (k == TOP_ORDER) ? LINK_W'(HIGH_HEAD) : NIL_L;
         end
      end else begin
         is_alloc_ff  <= is_alloc_in;
         lvl_ff       <= lvl_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         list_head_ff <= list_head_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == CMD_RSP) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result loaded over a pending transaction");
   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      32'(lvl_ff) <= TOP_ORDER)
      else $error("order register beyond top order");
   a_split_above_need: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == CMD_A_SPLIT) |-> (lvl_ff > need_ff))
      else $error("split below requested order");
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == CMD_RSP) |=> rsp_valid_ff)
      else $error("result not presented after load");
`endif
endmodule

FILE: rtl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Binary buddy page allocator: alloc by byte size, free by page index.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one request transaction (opcode, request_size, page_index);
//  rsp_* returns exactly one result transaction per request (status,
//  granted_page, granted_order), in request order.
//  One request is worked on at a time. The sequencer steps through the
//  table RAM accesses of an allocate or a free, several per order level.
//  After reset the tables are swept once, one page per cycle over all
//  NUM_PAGES pages, during which req_ready stays low.
//  A finished result sits in the output register; if the receiver stalls,
//  the next request is still taken and worked on, and its result waits
//  until the output register is free.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core #(
   parameter int NUM_PAGES = bpa_pkg::BPA_NUM_PAGES,
   parameter int TOP_ORDER = bpa_pkg::BPA_TOP_ORDER
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_payload
);
   import bpa_pkg::*;

   bpa_cmd_type  cmd;
   bpa_stat_type stat;

   bpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_ready(req_ready), .stat(stat), .cmd(cmd));

   bpa_datapath #(.NUM_PAGES(NUM_PAGES), .TOP_ORDER(TOP_ORDER)) u_dp (
      .clock(clock), .reset(reset), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .cmd(cmd), .stat(stat));
endmodule

FILE: tb/buddy_page_allocator_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_core_checker
// Watches the request and result channels, keeps its own copy of the page
// tables, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bpa_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bpa_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_count,
   output int               alloc_ok_count,
   output int               merge_count
);
   import bpa_pkg::*;

   localparam int NIL = BPA_NUM_PAGES;

   logic [2:0] pg_order [BPA_NUM_PAGES];
   logic       pg_free  [BPA_NUM_PAGES];
   logic       pg_head  [BPA_NUM_PAGES];
   int         nxt      [BPA_NUM_PAGES];
   int         prv      [BPA_NUM_PAGES];
   int         free_top [BPA_TOP_ORDER+1];
   rsp_type    expected_rsps [$];

   function automatic void list_push(int p, int k);
      nxt[p] = free_top[k];
      prv[p] = NIL;
      if (free_top[k] < NIL) prv[free_top[k]] = p;
      free_top[k] = p;
   endfunction

   function automatic void list_unlink(int p);
      int k;
      k = pg_order[p];
      if (prv[p] < NIL) nxt[prv[p]] = nxt[p];
      else free_top[k] = nxt[p];
      if (nxt[p] < NIL) prv[nxt[p]] = prv[p];
      nxt[p] = NIL;
      prv[p] = NIL;
   endfunction

   function automatic void tables_reset();
      for (int p = 0; p < BPA_NUM_PAGES; p++) begin
         pg_order[p] = 3'd0; pg_free[p] = 1'b0; pg_head[p] = 1'b0;
         nxt[p] = NIL; prv[p] = NIL;
      end
      for (int k = 0; k <= BPA_TOP_ORDER; k++) free_top[k] = NIL;
      for (int p = 0; p + (1 << BPA_TOP_ORDER) <= BPA_NUM_PAGES;
           p += (1 << BPA_TOP_ORDER)) begin
         pg_order[p] = 3'(BPA_TOP_ORDER); pg_free[p] = 1'b1; pg_head[p] = 1'b1;
         list_push(p, BPA_TOP_ORDER);
      end
   endfunction

   function automatic rsp_type allocator_step(req_type r);
      rsp_type o;
      int need, k, p, up, b, ord;
      logic fits;
      o = '0;
      if (r.opcode == OP_ALLOC) begin
         fits = 1'b0; need = 0;
         for (k = 0; k <= BPA_TOP_ORDER; k++)
            if (!fits && 64'(r.request_size) <= (64'(BPA_PAGE_BYTES) << k)) begin
               need = k; fits = 1'b1;
            end
         if (!fits) begin o.status = ST_TOO_LARGE; return o; end
         for (k = need; k <= BPA_TOP_ORDER; k++)
            if (free_top[k] < NIL) break;
         if (k > BPA_TOP_ORDER) begin o.status = ST_NO_FREE; return o; end
         p = free_top[k];
         list_unlink(p);
         for (int j = k; j > need; j--) begin
            up = p + (1 << (j - 1));
            if (up < BPA_NUM_PAGES) begin
               pg_order[up] = 3'(j - 1); pg_free[up] = 1'b1; pg_head[up] = 1'b1;
               list_push(up, j - 1);
            end
         end
         pg_order[p] = 3'(need); pg_free[p] = 1'b0; pg_head[p] = 1'b1;
         o.status = ST_OK; o.granted_page = 12'(p); o.granted_order = 3'(need);
         alloc_ok_count++;
      end else begin
         p = int'(r.page_index);
         if (!pg_head[p] || pg_free[p]) begin o.status = ST_BAD_FREE; return o; end
         ord = pg_order[p];
         while (ord < BPA_TOP_ORDER) begin
            b = p ^ (1 << ord);
            if (b >= BPA_NUM_PAGES || !pg_head[b] || !pg_free[b] || pg_order[b] != ord)
               break;
            list_unlink(b);
            if (b < p) begin
               pg_head[p] = 1'b0; pg_free[p] = 1'b0; pg_order[p] = 3'd0; p = b;
            end else begin
               pg_head[b] = 1'b0; pg_free[b] = 1'b0; pg_order[b] = 3'd0;
            end
            ord++;
            merge_count++;
         end
         pg_order[p] = 3'(ord); pg_free[p] = 1'b1; pg_head[p] = 1'b1;
         list_push(p, ord);
         o.status = ST_OK; o.granted_page = 12'(p); o.granted_order = 3'(ord);
      end
      return o;
   endfunction

   initial begin
      fail_count = 0; rsp_count = 0; alloc_ok_count = 0; merge_count = 0;
      tables_reset();
   end

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (req_valid && req_ready) expected_rsps.push_back(allocator_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transaction %h", $realtime, rsp_payload);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           exp_rsp.status, rsp_payload.status);
               end
               if (rsp_payload.granted_page !== exp_rsp.granted_page) begin
                  fail_count++;
                  $display("%0t: granted_page expected %0d actual %0d", $realtime,
                           exp_rsp.granted_page, rsp_payload.granted_page);
               end
               if (rsp_payload.granted_order !== exp_rsp.granted_order) begin
                  fail_count++;
                  $display("%0t: granted_order expected %0d actual %0d", $realtime,
                           exp_rsp.granted_order, rsp_payload.granted_order);
               end
            end
         end
      end
   end

endmodule

FILE: tb/buddy_page_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_core_tb
// Drives directed and random allocate/free transactions with random gaps
// and stalls, including one long result stall; the checker gives the count.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core_tb;
   import bpa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;

   int fail_count, pending_count, rsp_count, alloc_ok_count, merge_count;
   int cycle_count = 0;
   int sent_count = 0;
   int gap_next = 1;
   logic long_stall = 0;
   logic [11:0] held_pages [$];
   logic        op_fifo [$];

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   buddy_page_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   buddy_page_allocator_core_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count),
      .alloc_ok_count(alloc_ok_count), .merge_count(merge_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit reached");
         $display("buddy_page_allocator_core_tb: errors");
         $finish;
      end
   end

   // track pages granted by allocations so most frees are well formed
   always @(posedge clock)
      if (!reset) begin
         if (req_valid && req_ready) op_fifo.push_back(req_payload.opcode);
         if (rsp_valid && rsp_ready && op_fifo.size() != 0) begin
            if (op_fifo.pop_front() == OP_ALLOC && rsp_payload.status == ST_OK)
               held_pages.push_back(rsp_payload.granted_page);
         end
      end

   // valid drops only when a gap follows, so back-to-back items keep it high
   task automatic send(logic op, logic [31:0] sz, logic [11:0] pg);
      repeat (gap_next) @(posedge clock);
      req_valid <= 1;
      req_payload <= '{opcode: op, request_size: sz, page_index: pg};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      gap_next = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap_next = 0;
      if (gap_next != 0) req_valid <= 0;
   endtask

   task automatic idle_req();
      if (gap_next == 0) begin
         req_valid <= 0;
         gap_next = 1;
      end
   endtask

   function automatic logic [31:0] rand_size();
      int o;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'(BPA_PAGE_BYTES << BPA_TOP_ORDER) + $urandom_range(0, 1);
         default: begin
            o = $urandom_range(0, BPA_TOP_ORDER);
            return $urandom_range(0, BPA_PAGE_BYTES << o);
         end
      endcase
   endfunction

   task automatic free_held();
      int i;
      logic [11:0] pg;
      i = $urandom_range(0, held_pages.size() - 1);
      pg = held_pages[i];
      held_pages.delete(i);
      send(OP_FREE, $urandom(), pg);
   endtask

   // receiver: random stalls, plus one long hold-off
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (long_stall) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_stall = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 0;
            repeat (stall - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   initial begin
      int drain;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: size extremes, every status, coalescing
      send(OP_ALLOC, 32'd0, 12'd0);
      send(OP_ALLOC, 32'd1, 12'd0);
      send(OP_ALLOC, 32'(BPA_PAGE_BYTES), 12'd0);
      send(OP_ALLOC, 32'(BPA_PAGE_BYTES) + 1, 12'd0);
      send(OP_ALLOC, 32'(BPA_PAGE_BYTES << BPA_TOP_ORDER), 12'd0);
      send(OP_ALLOC, 32'(BPA_PAGE_BYTES << BPA_TOP_ORDER) + 1, 12'hfff);
      send(OP_ALLOC, 32'hffff_ffff, 12'hfff);
      send(OP_FREE, 32'hffff_ffff, 12'd1);
      send(OP_FREE, 32'd0, 12'hfff);
      send(OP_FREE, 32'd0, 12'd0);
      send(OP_FREE, 32'd0, 12'd0);
      send(OP_FREE, 32'd0, 12'd1);
      send(OP_FREE, 32'd0, 12'd2);
      send(OP_FREE, 32'd0, 12'd4);
      // exhaust the pool to reach the no-free-block case
      repeat (66) send(OP_ALLOC, 32'(BPA_PAGE_BYTES << BPA_TOP_ORDER), 12'd0);
      send(OP_ALLOC, 32'd0, 12'd0);
      idle_req();
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      // random: mostly frees of held blocks and fitting allocs
      long_stall = 1;
      for (int n = 0; n < 380; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3:
               if (held_pages.size() != 0) free_held();
               else send(OP_ALLOC, rand_size(), 12'($urandom()));
            4: send(OP_FREE, $urandom(), 12'($urandom()));
            default: send(OP_ALLOC, rand_size(), 12'($urandom()));
         endcase
      end
      idle_req();
      while (pending_count != 0) @(posedge clock);
      // give everything back to exercise deep merges
      while (held_pages.size() != 0) begin
         free_held();
         if (pending_count > 4) idle_req();
         while (pending_count > 4) @(posedge clock);
      end
      idle_req();
      drain = 0;
      while (pending_count != 0 || drain < 100) begin
         @(posedge clock);
         drain = (pending_count == 0) ? drain + 1 : 0;
      end

      $display("sent %0d requests, %0d results, %0d successful allocations, %0d merges",
               sent_count, rsp_count, alloc_ok_count, merge_count);
      if (fail_count == 0) $display("buddy_page_allocator_core_tb: clean");
      else $display("buddy_page_allocator_core_tb: errors");
      $finish;
   end

endmodule
